[hw/rtl/ppmfg_pkg.sv]
// Shared types, constants and register indexes for the PPM frame generator.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package ppmfg_pkg;

    // Default number of channels in one frame.
    localparam int CHANNEL_COUNT_DEF = 8;

    // Configuration register reset values.
    localparam logic [15:0] SPACE_USEC_RST = 16'd300;
    localparam logic [15:0] FRAME_USEC_RST = 16'd22500;
    localparam logic [15:0] MID_USEC_RST   = 16'd1200;
    localparam logic [14:0] RANGE_USEC_RST = 15'd500;
    localparam logic [15:0] INIT_USEC_RST  = 16'd1000;

    // Pulse width that every channel reads as after reset, until written.
    localparam logic [15:0] WIDTH_RST = 16'd1200;

    // Configuration register indexes (byte address divided by four).
    localparam logic [2:0] REG_SPACE = 3'd0;
    localparam logic [2:0] REG_FRAME = 3'd1;
    localparam logic [2:0] REG_MID   = 3'd2;
    localparam logic [2:0] REG_RANGE = 3'd3;
    localparam logic [2:0] REG_INIT  = 3'd4;

    // Input word modes.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Frame sequencer phases; each names the event that ends the running segment.
    typedef enum logic [1:0] {
        PH_START,
        PH_SPACE,
        PH_MARK,
        PH_LAST
    } phase_t;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] space_usec;
        logic [15:0] frame_usec;
        logic [15:0] mid_usec;
        logic [14:0] range_usec;
        logic [15:0] init_usec;
    } cfg_t;

    // Write request into the pulse width memory.
    typedef struct packed {
        logic        en;
        logic        bank;
        logic [3:0]  chan;
        logic [15:0] width;
    } mem_wr_t;

    // One result word.
    typedef struct packed {
        logic        pin_level;
        logic        frame_start;
        logic [15:0] overrun_count;
        logic [15:0] frame_time;
    } result_t;

endpackage

[hw/rtl/ppm_frame_generator_top.sv]
// PPM frame generator top level: register port, sequencer, width memory, result buffer.
// Depends on ppmfg_pkg and the ppmfg_regs, ppmfg_width_mem, ppmfg_seq, ppmfg_out_buf modules.
//
// Usage: each input word is either a one-microsecond tick (mode 0) or a channel
// write (mode 1, channel, signed value). Every accepted word yields exactly one
// result word with the line level, a frame start flag, the overrun count and the
// elapsed frame time. Both channels use valid/stall; a word moves when valid is
// high and stall is low.
// Throughput is one word per clock while item_stall is low, ticks and writes
// alike. Each result is registered in the result buffer. The sequencer handles
// each word combinationally; the width of the next mark is prefetched from the
// registered-read width memory using the sequencer's next state, so a mark can
// start on any tick. When the receiver stalls, results collect in an output
// register and a skid register; item_stall rises only once both hold a word.
// Reset restores the register defaults, starts a 1000-tick delay before the
// first frame and clears the memory's valid bits, so every channel width reads
// as 1200 until written. No clearing pass is needed; words are taken at once.
// Registers sit at byte addresses 0, 4, 8, 12 and 16 of the APB-style port.
`timescale 1ns / 1ps

module ppm_frame_generator_top
#(
    parameter int CHANNEL_COUNT = ppmfg_pkg::CHANNEL_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                mode,
    input  logic [3:0]          channel,
    input  logic signed [15:0]  value,
    output logic                result_valid,
    input  logic                result_stall,
    output logic                pin_level,
    output logic                frame_start,
    output logic [15:0]         overrun_count,
    output logic [15:0]         frame_time
);

    ppmfg_pkg::cfg_t      cfg;
    ppmfg_pkg::mem_wr_t   mem_wr;
    ppmfg_pkg::result_t   seq_result;
    ppmfg_pkg::result_t   out_data;
    logic                 rd_bank;
    logic [3:0]           rd_chan;
    logic [15:0]          mem_width;
    logic                 accept;
    logic                 buf_full;

    assign item_stall = buf_full;
    assign accept     = item_valid && !item_stall;

    // Configuration registers.
    ppmfg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Double-banked channel widths.
    ppmfg_width_mem #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (mem_wr),
        .rd_bank  (rd_bank),
        .rd_chan  (rd_chan),
        .rd_width (mem_width)
    );

    // Frame sequencer.
    ppmfg_seq #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (mode),
        .channel   (channel),
        .value     (value),
        .cfg       (cfg),
        .mem_width (mem_width),
        .mem_wr    (mem_wr),
        .rd_bank   (rd_bank),
        .rd_chan   (rd_chan),
        .result    (seq_result)
    );

    // Result buffer.
    ppmfg_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (seq_result),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (out_data)
    );

    assign pin_level     = out_data.pin_level;
    assign frame_start   = out_data.frame_start;
    assign overrun_count = out_data.overrun_count;
    assign frame_time    = out_data.frame_time;

    // The input side is held off only while a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n) item_stall |-> result_valid)
        else $error("input stalled with an empty output register");

    // A width write never lands in the bank being prefetched for playback.
    assert property (@(posedge clk) disable iff (!rst_n) mem_wr.en |-> (mem_wr.bank != rd_bank))
        else $error("width write collides with the playback bank");

    // A frame begins with the line low and the frame time at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (result_valid && frame_start) |-> (!pin_level && (frame_time == 16'd0)))
        else $error("frame start with wrong line level or frame time");

    // A word accepted into a free buffer shows up as a valid result on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> result_valid)
        else $error("accepted word produced no result");

endmodule

[hw/rtl/ppmfg_regs.sv]
// Configuration register file with its APB-style access port.
// Depends on ppmfg_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module ppmfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ppmfg_pkg::cfg_t     cfg
);

    ppmfg_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.space_usec <= ppmfg_pkg::SPACE_USEC_RST;
            cfg_reg.frame_usec <= ppmfg_pkg::FRAME_USEC_RST;
            cfg_reg.mid_usec   <= ppmfg_pkg::MID_USEC_RST;
            cfg_reg.range_usec <= ppmfg_pkg::RANGE_USEC_RST;
            cfg_reg.init_usec  <= ppmfg_pkg::INIT_USEC_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ppmfg_pkg::REG_SPACE: cfg_reg.space_usec <= pwdata[15:0];
                ppmfg_pkg::REG_FRAME: cfg_reg.frame_usec <= pwdata[15:0];
                ppmfg_pkg::REG_MID:   cfg_reg.mid_usec   <= pwdata[15:0];
                ppmfg_pkg::REG_RANGE: cfg_reg.range_usec <= pwdata[14:0];
                ppmfg_pkg::REG_INIT:  cfg_reg.init_usec  <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        unique case (reg_idx)
            ppmfg_pkg::REG_SPACE: prdata = {16'd0, cfg_reg.space_usec};
            ppmfg_pkg::REG_FRAME: prdata = {16'd0, cfg_reg.frame_usec};
            ppmfg_pkg::REG_MID:   prdata = {16'd0, cfg_reg.mid_usec};
            ppmfg_pkg::REG_RANGE: prdata = {17'd0, cfg_reg.range_usec};
            ppmfg_pkg::REG_INIT:  prdata = {16'd0, cfg_reg.init_usec};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

[hw/rtl/ppmfg_width_mem.sv]
// Two-bank pulse width memory: one write port, one registered read port.
// Depends on ppmfg_pkg for mem_wr_t and the reset width.
`timescale 1ns / 1ps

module ppmfg_width_mem
#(
    parameter int CHANNEL_COUNT = ppmfg_pkg::CHANNEL_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ppmfg_pkg::mem_wr_t   wr,
    input  logic                 rd_bank,
    input  logic [3:0]           rd_chan,
    output logic [15:0]          rd_width
);

    localparam int DEPTH = 2 * CHANNEL_COUNT;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0]      width_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [15:0]      rd_data_reg;
    logic             rd_valid_reg;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    // Bank one sits above bank zero.
    function automatic logic [AW-1:0] addr_of(input logic bank, input logic [3:0] chan);
        logic [AW-1:0] base;
        base    = bank ? AW'(CHANNEL_COUNT) : {AW{1'b0}};
        addr_of = base + AW'(chan);
    endfunction

    assign waddr = addr_of(wr.bank, wr.chan);
    assign raddr = addr_of(rd_bank, rd_chan);

    // Storage array and its registered read.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            width_mem[waddr] <= wr.width;
        end
        rd_data_reg <= width_mem[raddr];
    end

    // Per-entry valid bits; an entry never written reads as the reset width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
        end
    end

    assign rd_width = rd_valid_reg ? rd_data_reg : ppmfg_pkg::WIDTH_RST;

endmodule

[hw/rtl/ppmfg_seq.sv]
// Frame sequencer: segment timer, phase machine, bank control and value conversion.
// Depends on ppmfg_pkg; reads widths through a registered-read memory it prefetches.
`timescale 1ns / 1ps

module ppmfg_seq
#(
    parameter int CHANNEL_COUNT = ppmfg_pkg::CHANNEL_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 mode,
    input  logic [3:0]           channel,
    input  logic signed [15:0]   value,
    input  ppmfg_pkg::cfg_t      cfg,
    input  logic [15:0]          mem_width,
    output ppmfg_pkg::mem_wr_t   mem_wr,
    output logic                 rd_bank,
    output logic [3:0]           rd_chan,
    output ppmfg_pkg::result_t   result
);

    localparam logic [3:0] LAST_CHAN = 4'(CHANNEL_COUNT - 1);
    localparam logic [4:0] CHAN_LIM  = 5'(CHANNEL_COUNT);

    ppmfg_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  chan_idx_reg, chan_idx_next;
    logic [15:0] seg_left_reg, seg_left_next;
    logic [15:0] frame_cnt_reg, frame_cnt_next;
    logic        active_bank_reg, active_bank_next;
    logic        bank_done_reg, bank_done_next;
    logic [15:0] overrun_reg, overrun_next;
    logic        line_reg, line_next;

    logic        tick;
    logic        wr_item;
    logic        fire;
    logic        started;
    logic        chan_ok;
    logic [16:0] remain;
    logic [15:0] remain_len;
    logic [15:0] space_len;
    logic [15:0] mark_len;

    logic signed [16:0] half;
    logic signed [17:0] target;
    logic signed [17:0] lo_lim;
    logic signed [17:0] hi_lim;
    logic signed [17:0] clipped;
    logic [15:0]        conv_width;

    assign tick    = accept && (mode == ppmfg_pkg::MODE_TICK);
    assign wr_item = accept && (mode == ppmfg_pkg::MODE_WRITE);
    assign fire    = tick && (seg_left_reg <= 16'd1);
    assign chan_ok = {1'b0, channel} < CHAN_LIM;

    // Saturating frame time; a frame start clears it and a write word leaves it alone.
    always_comb
    begin
        frame_cnt_next = frame_cnt_reg;
        if (fire && (phase_reg == ppmfg_pkg::PH_START))
        begin
            frame_cnt_next = 16'd0;
        end
        else if (tick && (frame_cnt_reg != 16'hFFFF))
        begin
            frame_cnt_next = frame_cnt_reg + 16'd1;
        end
    end

    // Segment lengths; anything at or below zero lasts one tick.
    assign space_len  = (cfg.space_usec == 16'd0) ? 16'd1 : cfg.space_usec;
    assign mark_len   = (mem_width == 16'd0) ? 16'd1 : mem_width;
    assign remain     = {1'b0, cfg.frame_usec} - {1'b0, frame_cnt_next};
    assign remain_len = (remain[16] || (remain[15:0] == 16'd0)) ? 16'd1 : remain[15:0];

    // Channel value to pulse width: half the value rounded toward zero, then clipped.
    always_comb
    begin
        half    = (17'(value) >>> 1) + signed'({16'd0, value[15] & value[0]});
        target  = 18'(signed'({2'b00, cfg.mid_usec})) + 18'(half);
        lo_lim  = signed'({2'b00, cfg.mid_usec}) - signed'({3'b000, cfg.range_usec});
        hi_lim  = signed'({2'b00, cfg.mid_usec}) + signed'({3'b000, cfg.range_usec});
        clipped = target;
        if (clipped < lo_lim)
        begin
            clipped = lo_lim;
        end
        if (clipped > hi_lim)
        begin
            clipped = hi_lim;
        end
        if (clipped < 18'sd0)
        begin
            conv_width = 16'd0;
        end
        else if (clipped > 18'sd65535)
        begin
            conv_width = 16'hFFFF;
        end
        else
        begin
            conv_width = clipped[15:0];
        end
    end

    // Phase next state.
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            unique case (phase_reg)
                ppmfg_pkg::PH_START: phase_next = ppmfg_pkg::PH_SPACE;
                ppmfg_pkg::PH_SPACE: phase_next = ppmfg_pkg::PH_MARK;
                ppmfg_pkg::PH_MARK:  phase_next = (chan_idx_reg == LAST_CHAN) ?
                                                  ppmfg_pkg::PH_LAST : ppmfg_pkg::PH_SPACE;
                ppmfg_pkg::PH_LAST:  phase_next = ppmfg_pkg::PH_START;
            endcase
        end
    end

    // Event actions of the phase that ends, plus bank bookkeeping on writes.
    always_comb
    begin
        chan_idx_next    = chan_idx_reg;
        seg_left_next    = seg_left_reg;
        active_bank_next = active_bank_reg;
        bank_done_next   = bank_done_reg;
        overrun_next     = overrun_reg;
        line_next        = line_reg;
        started          = 1'b0;
        if (tick && !fire)
        begin
            seg_left_next = seg_left_reg - 16'd1;
        end
        else if (fire)
        begin
            unique case (phase_reg)
                ppmfg_pkg::PH_START:
                begin
                    line_next     = 1'b0;
                    seg_left_next = space_len;
                    started       = 1'b1;
                    if (bank_done_reg)
                    begin
                        bank_done_next   = 1'b0;
                        active_bank_next = ~active_bank_reg;
                    end
                    else
                    begin
                        overrun_next = overrun_reg + 16'd1;
                    end
                end
                ppmfg_pkg::PH_SPACE:
                begin
                    line_next     = 1'b1;
                    seg_left_next = mark_len;
                end
                ppmfg_pkg::PH_MARK:
                begin
                    line_next     = 1'b0;
                    seg_left_next = space_len;
                    chan_idx_next = (chan_idx_reg == LAST_CHAN) ? 4'd0 : chan_idx_reg + 4'd1;
                end
                ppmfg_pkg::PH_LAST:
                begin
                    line_next     = 1'b1;
                    seg_left_next = remain_len;
                end
            endcase
        end
        if (wr_item && ({1'b0, channel} == {1'b0, LAST_CHAN}))
        begin
            bank_done_next = 1'b1;
        end
    end

    // Writes go to the bank not being played.
    assign mem_wr.en    = wr_item && chan_ok;
    assign mem_wr.bank  = ~active_bank_reg;
    assign mem_wr.chan  = channel;
    assign mem_wr.width = conv_width;

    // Prefetch the width of the next state's channel so it is ready once the state registers take that state.
    assign rd_bank = active_bank_next;
    assign rd_chan = chan_idx_next;

    assign result.pin_level     = line_next;
    assign result.frame_start   = started;
    assign result.overrun_count = overrun_next;
    assign result.frame_time    = frame_cnt_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ppmfg_pkg::PH_START;
            chan_idx_reg    <= 4'd0;
            seg_left_reg    <= ppmfg_pkg::INIT_USEC_RST;
            frame_cnt_reg   <= 16'd0;
            active_bank_reg <= 1'b0;
            bank_done_reg   <= 1'b1;
            overrun_reg     <= 16'd0;
            line_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            chan_idx_reg    <= chan_idx_next;
            seg_left_reg    <= seg_left_next;
            frame_cnt_reg   <= frame_cnt_next;
            active_bank_reg <= active_bank_next;
            bank_done_reg   <= bank_done_next;
            overrun_reg     <= overrun_next;
            line_reg        <= line_next;
        end
    end

endmodule

[hw/rtl/ppmfg_out_buf.sv]
// Two-entry result buffer (output register plus skid register).
// Depends on ppmfg_pkg for result_t.
`timescale 1ns / 1ps

module ppmfg_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ppmfg_pkg::result_t   push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ppmfg_pkg::result_t   out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    ppmfg_pkg::result_t out_data_reg;
    ppmfg_pkg::result_t skid_data_reg;
    logic               drain;

    assign drain     = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (drain)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !drain)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (drain)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves; no reset needed.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !drain)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule
